[hdl/bounded_deque_with_indexed_read_defines.svh]
// Assertion macros used by the deque's top-level RTL file.
`ifndef BOUNDED_DEQUE_WITH_INDEXED_READ_DEFINES_SVH
`define BOUNDED_DEQUE_WITH_INDEXED_READ_DEFINES_SVH

// Same-cycle implication, checked on clk and disabled during rst.
`define BDQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deque same-cycle check failed");

// Next-cycle implication, checked on clk and disabled during rst.
`define BDQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deque next-cycle check failed");

`endif

[hdl/bdq_pkg.sv]
// Shared types and constants of the bounded deque.
package bdq_pkg;

  // Default storage geometry.
  localparam int unsigned CAPACITY_DEF      = 256;
  localparam int unsigned PAYLOAD_WIDTH_DEF = 32;

  // Fixed field widths of the command and response channels.
  localparam int unsigned CMD_W      = 3;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned POS_W      = 8;
  localparam int unsigned ECOUNT_W   = 9;
  localparam int unsigned STATUS_W   = 2;

  // Command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_INS_HEAD = 3'd0,
    CMD_INS_TAIL = 3'd1,
    CMD_REM_HEAD = 3'd2,
    CMD_REM_TAIL = 3'd3,
    CMD_RD_HEAD  = 3'd4,
    CMD_RD_TAIL  = 3'd5,
    CMD_RD_POS   = 3'd6
  } cmd_t;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

  // Per-command result information carried alongside the memory access.
  typedef struct packed {
    logic                rd_hit;
    logic [STATUS_W-1:0] status;
    logic [ECOUNT_W-1:0] count;
  } bdq_info_t;

endpackage

[hdl/bounded_deque_with_indexed_read.sv]
// Bounded double-ended queue with indexed read: top level.
//
// Usage: the command channel (cmd_valid/cmd_ready) carries command, payload
// and position; one transfer there gives exactly one transfer on the response
// channel (rsp_valid/rsp_ready) with read_data, element_count and status.
// Commands: insert head or tail, remove head or tail, read head or tail, and
// read at a position counted from the head. Full inserts, accesses on an
// empty queue and reads past the last entry change nothing and are flagged
// in status; read_data is zero unless a read succeeds.
// A command transfer passes through the memory stage, where the synchronous
// entry memory access completes, and then through the response register.
// Throughput is one command per cycle while the receiver takes responses, set
// by the single memory port, which serves at most one access per command.
// Reset empties the queue and drops any response in flight; entry contents
// are not cleared. When the receiver stalls, the response register and the
// memory stage behind it fill, and cmd_ready falls until rsp_ready returns.
`include "bounded_deque_with_indexed_read_defines.svh"

module bounded_deque_with_indexed_read #(
  parameter int unsigned CAPACITY      = bdq_pkg::CAPACITY_DEF,
  parameter int unsigned PAYLOAD_WIDTH = bdq_pkg::PAYLOAD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_ready,
  input  logic [bdq_pkg::CMD_W-1:0]     command,
  input  logic [bdq_pkg::WORD_W-1:0]    payload,
  input  logic [bdq_pkg::POS_W-1:0]     position,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output logic [bdq_pkg::WORD_W-1:0]    read_data,
  output logic [bdq_pkg::ECOUNT_W-1:0]  element_count,
  output logic [bdq_pkg::STATUS_W-1:0]  status
);

  localparam int unsigned AW = $clog2(CAPACITY);

  logic                     fire;
  logic                     mem_we;
  logic                     mem_re;
  logic [AW-1:0]            mem_addr;
  logic [PAYLOAD_WIDTH-1:0] mem_wdata;
  logic [PAYLOAD_WIDTH-1:0] mem_rdata;
  bdq_pkg::bdq_info_t       info;

  logic                     p1_valid;
  bdq_pkg::bdq_info_t       p1_info;
  logic                     p1_move;

  // Handshake: the memory stage moves on when the response register is free.
  assign p1_move   = p1_valid & (~rsp_valid | rsp_ready);
  assign cmd_ready = ~p1_valid | p1_move;
  assign fire      = cmd_valid & cmd_ready;

  bdq_ctrl #(
    .CAPACITY      (CAPACITY),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .command   (command),
    .payload   (payload),
    .position  (position),
    .mem_we    (mem_we),
    .mem_re    (mem_re),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .info      (info)
  );

  bdq_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (PAYLOAD_WIDTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Memory stage: holds the result information while the read completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (fire) begin
      p1_valid <= 1'b1;
    end else if (p1_move) begin
      p1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      p1_info <= info;
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (p1_move) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_move) begin
      read_data     <= p1_info.rd_hit ? bdq_pkg::WORD_W'(mem_rdata) : '0;
      element_count <= p1_info.count;
      status        <= p1_info.status;
    end
  end

  // A command is refused only while both stages are full and the receiver stalls.
  `BDQ_ASSERT_NOW(a_ready_only_on_stall, !cmd_ready, p1_valid && rsp_valid && !rsp_ready)
  // A stalled memory-stage result is kept, not dropped.
  `BDQ_ASSERT_NEXT(a_p1_held, p1_valid && !p1_move, p1_valid)
  // Flagged responses never carry read data.
  `BDQ_ASSERT_NOW(a_flag_zero_data, rsp_valid && status != bdq_pkg::ST_OK, read_data == '0)

endmodule

[hdl/bdq_mem.sv]
// Single-port entry memory with a registered read.
module bdq_mem #(
  parameter int unsigned DEPTH = bdq_pkg::CAPACITY_DEF,
  parameter int unsigned WIDTH = bdq_pkg::PAYLOAD_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // Read port; data is registered and appears in the cycle after the request.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

[hdl/bdq_ctrl.sv]
// Ring pointer and count control of the deque: decodes commands into memory accesses.
module bdq_ctrl #(
  parameter int unsigned CAPACITY      = bdq_pkg::CAPACITY_DEF,
  parameter int unsigned PAYLOAD_WIDTH = bdq_pkg::PAYLOAD_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         fire,
  input  logic [bdq_pkg::CMD_W-1:0]    command,
  input  logic [bdq_pkg::WORD_W-1:0]   payload,
  input  logic [bdq_pkg::POS_W-1:0]    position,
  output logic                         mem_we,
  output logic                         mem_re,
  output logic [$clog2(CAPACITY)-1:0]  mem_addr,
  output logic [PAYLOAD_WIDTH-1:0]     mem_wdata,
  output bdq_pkg::bdq_info_t           info
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = (CW > bdq_pkg::POS_W) ? CW : bdq_pkg::POS_W;

  logic [AW-1:0] head;
  logic [AW-1:0] head_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  logic          full;
  logic          empty;
  logic          out_of_range;
  logic [AW-1:0] head_dec;
  logic [AW-1:0] head_inc;
  logic [CW-1:0] offset;
  logic [AW:0]   ring_sum;
  logic [AW-1:0] ring_idx;
  logic          we_int;
  logic          re_int;
  logic [bdq_pkg::STATUS_W-1:0] status;

  // Occupancy and range checks.
  assign full         = (count >= CW'(CAPACITY));
  assign empty        = (count == '0);
  assign out_of_range = (XW'(position) >= XW'(count));

  // Neighbor head positions on the ring.
  assign head_dec = (head == '0) ? AW'(CAPACITY - 1) : head - 1'b1;
  assign head_inc = (head == AW'(CAPACITY - 1)) ? '0 : head + 1'b1;

  // Offset from the head for the tail and positional accesses.
  always_comb begin
    unique case (bdq_pkg::cmd_t'(command))
      bdq_pkg::CMD_INS_TAIL: offset = count;
      bdq_pkg::CMD_RD_TAIL:  offset = count - 1'b1;
      bdq_pkg::CMD_RD_POS:   offset = CW'(position);
      default:               offset = '0;
    endcase
  end

  // Ring index: the sum stays below twice the capacity, so one subtract wraps it.
  assign ring_sum = {1'b0, head} + (AW + 1)'(offset);
  assign ring_idx = (ring_sum >= (AW + 1)'(CAPACITY)) ?
                    AW'(ring_sum - (AW + 1)'(CAPACITY)) : AW'(ring_sum);

  // Command decode.
  always_comb begin
    head_next  = head;
    count_next = count;
    we_int     = 1'b0;
    re_int     = 1'b0;
    mem_addr   = ring_idx;
    status     = bdq_pkg::ST_OK;
    unique case (bdq_pkg::cmd_t'(command)) inside
      bdq_pkg::CMD_INS_HEAD: begin
        if (full) begin
          status = bdq_pkg::ST_FULL;
        end else begin
          head_next  = head_dec;
          count_next = count + 1'b1;
          mem_addr   = head_dec;
          we_int     = 1'b1;
        end
      end
      bdq_pkg::CMD_INS_TAIL: begin
        if (full) begin
          status = bdq_pkg::ST_FULL;
        end else begin
          count_next = count + 1'b1;
          we_int     = 1'b1;
        end
      end
      bdq_pkg::CMD_REM_HEAD: begin
        if (empty) begin
          status = bdq_pkg::ST_EMPTY;
        end else begin
          head_next  = head_inc;
          count_next = count - 1'b1;
        end
      end
      bdq_pkg::CMD_REM_TAIL: begin
        if (empty) begin
          status = bdq_pkg::ST_EMPTY;
        end else begin
          count_next = count - 1'b1;
        end
      end
      bdq_pkg::CMD_RD_HEAD, bdq_pkg::CMD_RD_TAIL: begin
        if (empty) begin
          status = bdq_pkg::ST_EMPTY;
        end else begin
          re_int = 1'b1;
        end
      end
      bdq_pkg::CMD_RD_POS: begin
        if (empty) begin
          status = bdq_pkg::ST_EMPTY;
        end else if (out_of_range) begin
          status = bdq_pkg::ST_RANGE;
        end else begin
          re_int = 1'b1;
        end
      end
      default: begin
        status = bdq_pkg::ST_OK;
      end
    endcase
  end

  assign mem_we    = fire & we_int;
  assign mem_re    = fire & re_int;
  assign mem_wdata = PAYLOAD_WIDTH'(payload);

  assign info.rd_hit = re_int;
  assign info.status = status;
  assign info.count  = bdq_pkg::ECOUNT_W'(count_next);

  // Head pointer and count are updated on each transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (fire) begin
      head  <= head_next;
      count <= count_next;
    end
  end

endmodule

[dv/bounded_deque_with_indexed_read_tb.sv]
// Self-checking testbench for the bounded deque with indexed read.
`timescale 1ns / 1ps

module bounded_deque_with_indexed_read_tb;

  localparam int unsigned DEPTH = bdq_pkg::CAPACITY_DEF;
  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int unsigned SETTLE_CYCLES = 8;
  // Code 7 has no meaning; the block must leave its state alone.
  localparam logic [bdq_pkg::CMD_W-1:0] CMD_UNUSED = 3'd7;

  // One response as the block should present it.
  typedef struct packed {
    logic [bdq_pkg::WORD_W-1:0]   data;
    logic [bdq_pkg::ECOUNT_W-1:0] count;
    logic [bdq_pkg::STATUS_W-1:0] status;
  } deque_rsp_t;

  // Shadow deque that predicts each response and checks the block's output.
  class deque_scoreboard;
    logic [bdq_pkg::WORD_W-1:0] entries[DEPTH];
    int unsigned                head;
    int unsigned                count;
    deque_rsp_t                 awaited[$];
    int unsigned                errors;

    function new();
      head = 0;
      count = 0;
      errors = 0;
    endfunction

    function int unsigned level();
      return count;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    // Apply one accepted command to the shadow ring and queue its response.
    function void note_command(logic [bdq_pkg::CMD_W-1:0] op,
                               logic [bdq_pkg::WORD_W-1:0] word,
                               logic [bdq_pkg::POS_W-1:0] pos);
      deque_rsp_t r;
      r.data = '0;
      r.status = bdq_pkg::ST_OK;
      case (op)
        bdq_pkg::CMD_INS_HEAD: begin
          if (count >= DEPTH) begin
            r.status = bdq_pkg::ST_FULL;
          end else begin
            head = (head + DEPTH - 1) % DEPTH;
            entries[head] = word;
            count++;
          end
        end
        bdq_pkg::CMD_INS_TAIL: begin
          if (count >= DEPTH) begin
            r.status = bdq_pkg::ST_FULL;
          end else begin
            entries[(head + count) % DEPTH] = word;
            count++;
          end
        end
        bdq_pkg::CMD_REM_HEAD: begin
          if (count == 0) begin
            r.status = bdq_pkg::ST_EMPTY;
          end else begin
            head = (head + 1) % DEPTH;
            count--;
          end
        end
        bdq_pkg::CMD_REM_TAIL: begin
          if (count == 0) r.status = bdq_pkg::ST_EMPTY;
          else count--;
        end
        bdq_pkg::CMD_RD_HEAD: begin
          if (count == 0) r.status = bdq_pkg::ST_EMPTY;
          else r.data = entries[head];
        end
        bdq_pkg::CMD_RD_TAIL: begin
          if (count == 0) r.status = bdq_pkg::ST_EMPTY;
          else r.data = entries[(head + count - 1) % DEPTH];
        end
        bdq_pkg::CMD_RD_POS: begin
          if (count == 0) r.status = bdq_pkg::ST_EMPTY;
          else if (pos >= count) r.status = bdq_pkg::ST_RANGE;
          else r.data = entries[(head + pos) % DEPTH];
        end
        default: begin
        end
      endcase
      r.count = bdq_pkg::ECOUNT_W'(count);
      awaited.push_back(r);
    endfunction

    // Compare one response transfer against the oldest prediction.
    function void check_response(logic [bdq_pkg::WORD_W-1:0] data,
                                 logic [bdq_pkg::ECOUNT_W-1:0] cnt,
                                 logic [bdq_pkg::STATUS_W-1:0] st);
      deque_rsp_t exp;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: unexpected response: data %h count %0d status %0d",
                 $time, data, cnt, st);
        return;
      end
      exp = awaited.pop_front();
      if (data !== exp.data) begin
        errors++;
        $display("%0t: read_data mismatch: expected %h actual %h", $time, exp.data, data);
      end
      if (cnt !== exp.count) begin
        errors++;
        $display("%0t: element_count mismatch: expected %0d actual %0d",
                 $time, exp.count, cnt);
      end
      if (st !== exp.status) begin
        errors++;
        $display("%0t: status mismatch: expected %0d actual %0d", $time, exp.status, st);
      end
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cmd_valid = 1'b0;
  logic                         cmd_ready;
  logic [bdq_pkg::CMD_W-1:0]    command = '0;
  logic [bdq_pkg::WORD_W-1:0]   payload = '0;
  logic [bdq_pkg::POS_W-1:0]    position = '0;
  logic                         rsp_valid;
  logic                         rsp_ready = 1'b0;
  logic [bdq_pkg::WORD_W-1:0]   read_data;
  logic [bdq_pkg::ECOUNT_W-1:0] element_count;
  logic [bdq_pkg::STATUS_W-1:0] status;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned cycle_count = 0;
  bit          growing = 1'b1;

  deque_scoreboard model = new();

  bounded_deque_with_indexed_read DUT (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready),
    .command       (command),
    .payload       (payload),
    .position      (position),
    .rsp_valid     (rsp_valid),
    .rsp_ready     (rsp_ready),
    .read_data     (read_data),
    .element_count (element_count),
    .status        (status)
  );

  // Free-running clock.
  initial begin
    forever #1 clk = ~clk;
  end

  // Run limit in case the block hangs.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("bounded_deque_with_indexed_read regression: fail");
    $finish;
  end

  // Response side: check each transfer, then pick the next ready value.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && rsp_ready) begin
        model.check_response(read_data, element_count, status);
      end
      @(negedge clk);
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Present one command, with random idle cycles ahead of it, until transfer.
  task automatic send_cmd(input logic [bdq_pkg::CMD_W-1:0] op,
                          input logic [bdq_pkg::WORD_W-1:0] word,
                          input logic [bdq_pkg::POS_W-1:0] pos);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd_valid <= 1'b1;
    command <= op;
    payload <= word;
    position <= pos;
    do @(posedge clk); while (!cmd_ready);
    model.note_command(op, word, pos);
  endtask

  // Stop sending and wait for every outstanding response.
  task automatic hold_until_drained();
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (model.pending() != 0) @(negedge clk);
  endtask

  // Read positions cluster inside the list and around its last entry, with some drawn anywhere in range.
  function automatic logic [bdq_pkg::POS_W-1:0] pick_position(int unsigned cnt);
    int p;
    int unsigned sel;
    sel = $urandom_range(3);
    if (sel < 2 && cnt > 0) begin
      p = $urandom_range(cnt - 1);
    end else if (sel == 2) begin
      p = int'(cnt) + int'($urandom_range(2)) - 1;
    end else begin
      p = $urandom_range(255);
    end
    if (p < 0) p = 0;
    if (p > 255) p = 255;
    return bdq_pkg::POS_W'(p);
  endfunction

  // Random commands, biased to fill the list to capacity and then drain it.
  task automatic run_random(input int unsigned n);
    int unsigned done_items;
    int unsigned roll;
    int unsigned pick;
    logic [bdq_pkg::CMD_W-1:0]  op;
    logic [bdq_pkg::WORD_W-1:0] word;
    done_items = 0;
    while (done_items < n) begin
      if (growing && model.level() == DEPTH && $urandom_range(3) == 0) begin
        growing = 1'b0;
      end else if (!growing && model.level() == 0 && $urandom_range(3) == 0) begin
        growing = 1'b1;
      end
      roll = $urandom_range(99);
      pick = $urandom_range(2);
      if (roll < (growing ? 80 : 10)) begin
        op = pick[0] ? bdq_pkg::CMD_INS_TAIL : bdq_pkg::CMD_INS_HEAD;
      end else if (roll < (growing ? 84 : 80)) begin
        op = pick[0] ? bdq_pkg::CMD_REM_TAIL : bdq_pkg::CMD_REM_HEAD;
      end else if (roll < 98) begin
        op = (pick == 0) ? bdq_pkg::CMD_RD_HEAD :
             (pick == 1) ? bdq_pkg::CMD_RD_TAIL : bdq_pkg::CMD_RD_POS;
      end else begin
        op = CMD_UNUSED;
      end
      case ($urandom_range(9))
        0: word = '0;
        1: word = '1;
        default: word = $urandom();
      endcase
      send_cmd(op, word, pick_position(model.level()));
      if (op != CMD_UNUSED) done_items++;
    end
  endtask

  // Main sequence: reset, directed cases, then three idling phases.
  initial begin
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // Empty-list accesses and the unused code.
    send_cmd(bdq_pkg::CMD_RD_HEAD, '0, '0);
    send_cmd(bdq_pkg::CMD_RD_TAIL, '0, '0);
    send_cmd(bdq_pkg::CMD_RD_POS, '0, '0);
    send_cmd(bdq_pkg::CMD_RD_POS, '0, 8'hFF);
    send_cmd(bdq_pkg::CMD_REM_HEAD, '0, '0);
    send_cmd(bdq_pkg::CMD_REM_TAIL, '0, '0);
    send_cmd(CMD_UNUSED, '1, 8'hFF);
    // Insert at both ends, with extreme payloads.
    send_cmd(bdq_pkg::CMD_INS_TAIL, 32'h0000_0000, '0);
    send_cmd(bdq_pkg::CMD_INS_HEAD, 32'hFFFF_FFFF, '0);
    send_cmd(bdq_pkg::CMD_INS_TAIL, 32'hA5A5_5A5A, 8'hFF);
    send_cmd(bdq_pkg::CMD_INS_HEAD, 32'h8000_0001, '0);
    // Reads at every end and position, including just past the last entry.
    send_cmd(bdq_pkg::CMD_RD_HEAD, '0, '0);
    send_cmd(bdq_pkg::CMD_RD_TAIL, '0, '0);
    send_cmd(bdq_pkg::CMD_RD_POS, '0, 8'd0);
    send_cmd(bdq_pkg::CMD_RD_POS, '0, 8'd1);
    send_cmd(bdq_pkg::CMD_RD_POS, '0, 8'd2);
    send_cmd(bdq_pkg::CMD_RD_POS, '0, 8'd3);
    send_cmd(bdq_pkg::CMD_RD_POS, '0, 8'd4);
    send_cmd(bdq_pkg::CMD_RD_POS, '0, 8'hFF);
    send_cmd(CMD_UNUSED, 32'h1234_5678, 8'd1);
    // Removes from both ends, then reads of what is left.
    send_cmd(bdq_pkg::CMD_REM_HEAD, '1, '0);
    send_cmd(bdq_pkg::CMD_REM_TAIL, '1, '0);
    send_cmd(bdq_pkg::CMD_RD_HEAD, '0, '0);
    send_cmd(bdq_pkg::CMD_RD_TAIL, '0, '0);
    hold_until_drained();

    send_idle_pct = 12;
    recv_idle_pct = 48;
    run_random(140);
    hold_until_drained();

    send_idle_pct = 48;
    recv_idle_pct = 12;
    run_random(140);
    hold_until_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(140);
    hold_until_drained();

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (model.errors == 0 && model.pending() == 0) begin
      $display("bounded_deque_with_indexed_read regression: pass");
    end else begin
      $display("bounded_deque_with_indexed_read regression: fail");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/bdq_pkg.sv
hdl/bdq_mem.sv
hdl/bdq_ctrl.sv
hdl/bounded_deque_with_indexed_read.sv
dv/bounded_deque_with_indexed_read_tb.sv
